[src/byte_ring_fifo_with_peek_assert.svh]
// Assertion macros used by the RTL of the byte ring FIFO.
`ifndef BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH

// Checks a condition at every rising clock edge outside reset.
`define BRF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the same cycle.
`define BRF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/brf_pkg.sv]
package brf_pkg;

    localparam int DEPTH     = 1024;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int MAX_BURST = 64;
    localparam int LEN_W     = 7;
    localparam int OFF_W     = 10;
    localparam int FILL_W    = 10;
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int SUM_W     = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;

    localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OP_W-1:0] OP_READ    = 3'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_ONE   = 5'b00100,
        S_ISSUE = 5'b01000,
        S_HOLD  = 5'b10000
    } t_state;

endpackage

[src/byte_ring_fifo_with_peek.sv]
// A write, discard, clear, empty read, refused peek or unused code passes through EXEC and ONE
// and gives one status result. A read or peek burst passes through EXEC, ISSUE and HOLD;
// in HOLD it gives one byte per cycle while the output is not stalled, as the single memory
// read port allows. A new transaction is accepted only after the last result is registered.
// Reset clears both positions and the control state; the byte store keeps its contents.
`include "byte_ring_fifo_with_peek_assert.svh"

module byte_ring_fifo_with_peek (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [brf_pkg::OP_W-1:0]      i_op,
    input  logic [brf_pkg::BYTE_W-1:0]    i_write_byte,
    input  logic [brf_pkg::LEN_W-1:0]     i_length,
    input  logic [brf_pkg::OFF_W-1:0]     i_peek_offset,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [brf_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_byte_valid,
    output logic                          o_last,
    output logic [brf_pkg::LEN_W-1:0]     o_count,
    output logic [brf_pkg::FILL_W-1:0]    o_fill_level,
    output logic [brf_pkg::FILL_W-1:0]    o_free_space
);

    brf_pkg::t_state r_state, n_state;

    logic [brf_pkg::BYTE_W-1:0] r_mem [brf_pkg::DEPTH];
    logic [brf_pkg::BYTE_W-1:0] r_rdata;

    logic [brf_pkg::PTR_W-1:0]  r_rp, n_rp;
    logic [brf_pkg::PTR_W-1:0]  r_wp, n_wp;
    logic [brf_pkg::PTR_W-1:0]  r_addr, n_addr;
    logic [brf_pkg::LEN_W-1:0]  r_left, n_left;

    logic [brf_pkg::OP_W-1:0]   r_op;
    logic [brf_pkg::BYTE_W-1:0] r_wbyte;
    logic [brf_pkg::LEN_W-1:0]  r_len;
    logic [brf_pkg::OFF_W-1:0]  r_off;

    logic [brf_pkg::LEN_W-1:0]  r_cnt, n_cnt;
    logic [brf_pkg::PTR_W-1:0]  r_fill_after, n_fill_after;

    logic                       r_out_valid, n_out_valid;
    logic [brf_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                       r_byte_valid, n_byte_valid;
    logic                       r_last, n_last;
    logic [brf_pkg::LEN_W-1:0]  r_count, n_count;
    logic [brf_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [brf_pkg::FILL_W-1:0] r_free, n_free;

    logic                       accept;
    logic                       out_free;
    logic                       mem_we;
    logic                       mem_re;
    logic [brf_pkg::PTR_W-1:0]  fill;
    logic [brf_pkg::LEN_W-1:0]  take;
    logic                       peek_ok;

    assign accept   = i_valid && (r_state == brf_pkg::S_IDLE);
    assign o_stall  = (r_state != brf_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    assign fill = r_wp - r_rp;
    assign take = (brf_pkg::SUM_W'(r_len) < brf_pkg::SUM_W'(fill)) ?
                  r_len : brf_pkg::LEN_W'(fill);
    assign peek_ok = (r_len != '0) &&
                     ((brf_pkg::SUM_W'(r_off) + brf_pkg::SUM_W'(r_len)) <=
                      brf_pkg::SUM_W'(fill));

    assign mem_we = (r_state == brf_pkg::S_EXEC) && (r_op == brf_pkg::OP_WRITE) &&
                    (fill != brf_pkg::PTR_W'(brf_pkg::DEPTH - 1));
    assign mem_re = (r_state == brf_pkg::S_ISSUE) ||
                    ((r_state == brf_pkg::S_HOLD) && out_free &&
                     (r_left != brf_pkg::LEN_W'(1)));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= r_wbyte;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_addr       = r_addr;
        n_left       = r_left;
        n_cnt        = r_cnt;
        n_fill_after = r_fill_after;
        n_out_valid  = r_out_valid && i_stall;
        n_out_byte   = r_out_byte;
        n_byte_valid = r_byte_valid;
        n_last       = r_last;
        n_count      = r_count;
        n_fill       = r_fill;
        n_free       = r_free;
        unique case (r_state)
            brf_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = brf_pkg::S_EXEC;
                end
            end
            brf_pkg::S_EXEC: begin
                n_cnt        = '0;
                n_fill_after = fill;
                n_state      = brf_pkg::S_ONE;
                unique case (r_op)
                    brf_pkg::OP_WRITE: begin
                        if (mem_we) begin
                            n_wp         = r_wp + brf_pkg::PTR_W'(1);
                            n_cnt        = brf_pkg::LEN_W'(1);
                            n_fill_after = fill + brf_pkg::PTR_W'(1);
                        end
                    end
                    brf_pkg::OP_READ, brf_pkg::OP_DISCARD: begin
                        n_rp         = r_rp + brf_pkg::PTR_W'(take);
                        n_cnt        = take;
                        n_fill_after = fill - brf_pkg::PTR_W'(take);
                        n_addr       = r_rp;
                        n_left       = take;
                        if ((r_op == brf_pkg::OP_READ) && (take != '0)) begin
                            n_state = brf_pkg::S_ISSUE;
                        end
                    end
                    brf_pkg::OP_PEEK: begin
                        n_addr = r_rp + brf_pkg::PTR_W'(r_off);
                        n_left = r_len;
                        if (peek_ok) begin
                            n_cnt   = r_len;
                            n_state = brf_pkg::S_ISSUE;
                        end
                    end
                    brf_pkg::OP_CLEAR: begin
                        n_rp         = '0;
                        n_wp         = '0;
                        n_fill_after = '0;
                    end
                    default: begin
                    end
                endcase
            end
            brf_pkg::S_ONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_byte_valid = 1'b0;
                    n_last       = 1'b1;
                    n_count      = r_cnt;
                    n_fill       = brf_pkg::FILL_W'(r_fill_after);
                    n_free       = brf_pkg::FILL_W'(~r_fill_after);
                    n_state      = brf_pkg::S_IDLE;
                end
            end
            brf_pkg::S_ISSUE: begin
                n_addr  = r_addr + brf_pkg::PTR_W'(1);
                n_state = brf_pkg::S_HOLD;
            end
            brf_pkg::S_HOLD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_rdata;
                    n_byte_valid = 1'b1;
                    n_last       = (r_left == brf_pkg::LEN_W'(1));
                    n_count      = r_cnt;
                    n_fill       = brf_pkg::FILL_W'(r_fill_after);
                    n_free       = brf_pkg::FILL_W'(~r_fill_after);
                    n_left       = r_left - brf_pkg::LEN_W'(1);
                    if (r_left == brf_pkg::LEN_W'(1)) begin
                        n_state = brf_pkg::S_IDLE;
                    end else begin
                        n_addr = r_addr + brf_pkg::PTR_W'(1);
                    end
                end
            end
            default: begin
                n_state = brf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brf_pkg::S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_wbyte <= i_write_byte;
            r_len   <= (i_length > brf_pkg::LEN_W'(brf_pkg::MAX_BURST)) ?
                       brf_pkg::LEN_W'(brf_pkg::MAX_BURST) : i_length;
            r_off   <= i_peek_offset;
        end
        r_addr       <= n_addr;
        r_left       <= n_left;
        r_cnt        <= n_cnt;
        r_fill_after <= n_fill_after;
        r_out_byte   <= n_out_byte;
        r_byte_valid <= n_byte_valid;
        r_last       <= n_last;
        r_count      <= n_count;
        r_fill       <= n_fill;
        r_free       <= n_free;
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_last       = r_last;
    assign o_count      = r_count;
    assign o_fill_level = r_fill;
    assign o_free_space = r_free;

    `BRF_ASSERT_IMPL(a_byte_has_count, r_out_valid && r_byte_valid, r_count != '0, "byte without count")
    `BRF_ASSERT_IMPL(a_single_is_last, r_out_valid && !r_byte_valid, r_last, "single result not last")
    `BRF_ASSERT_IMPL(a_hold_left, r_state == brf_pkg::S_HOLD, r_left != '0, "burst counter empty")
    `BRF_ASSERT_IMPL(a_fill_sum, r_out_valid, brf_pkg::PTR_W'(r_fill + r_free) == brf_pkg::PTR_W'(brf_pkg::DEPTH - 1), "fill and free mismatch")

endmodule

[tb/sv/tb_byte_ring_fifo_with_peek.sv]
`timescale 1ns / 1ps

module tb_byte_ring_fifo_with_peek;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PRELOAD_BYTES  = 70;
    localparam int RANDOM_CMDS    = 375;

    localparam logic [brf_pkg::OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [brf_pkg::OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [brf_pkg::OP_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [brf_pkg::OP_W-1:0]   op;
        logic [brf_pkg::BYTE_W-1:0] write_byte;
        logic [brf_pkg::LEN_W-1:0]  length;
        logic [brf_pkg::OFF_W-1:0]  peek_offset;
    } t_fifo_cmd;

    typedef struct packed {
        logic [brf_pkg::BYTE_W-1:0] out_byte;
        logic                       byte_valid;
        logic                       last;
        logic [brf_pkg::LEN_W-1:0]  count;
        logic [brf_pkg::FILL_W-1:0] fill_level;
        logic [brf_pkg::FILL_W-1:0] free_space;
    } t_fifo_result;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       o_stall;
    logic [brf_pkg::OP_W-1:0]   i_op          = '0;
    logic [brf_pkg::BYTE_W-1:0] i_write_byte  = '0;
    logic [brf_pkg::LEN_W-1:0]  i_length      = '0;
    logic [brf_pkg::OFF_W-1:0]  i_peek_offset = '0;
    logic                       o_valid;
    logic                       i_stall       = 1'b0;
    logic [brf_pkg::BYTE_W-1:0] o_out_byte;
    logic                       o_byte_valid;
    logic                       o_last;
    logic [brf_pkg::LEN_W-1:0]  o_count;
    logic [brf_pkg::FILL_W-1:0] o_fill_level;
    logic [brf_pkg::FILL_W-1:0] o_free_space;

    byte_ring_fifo_with_peek u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_write_byte  (i_write_byte),
        .i_length      (i_length),
        .i_peek_offset (i_peek_offset),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last        (o_last),
        .o_count       (o_count),
        .o_fill_level  (o_fill_level),
        .o_free_space  (o_free_space)
    );

    t_fifo_cmd                  cmd_queue[$];
    t_fifo_result               exp_results[$];
    logic [brf_pkg::BYTE_W-1:0] shadow_mem [brf_pkg::DEPTH];
    logic [brf_pkg::PTR_W-1:0]  rd_ptr = '0;
    logic [brf_pkg::PTR_W-1:0]  wr_ptr = '0;
    t_fifo_cmd                  cur_cmd;
    int unsigned                src_gap   = 0;
    int unsigned                snk_wait  = 0;
    bit                         src_quiet = 1'b0;
    bit                         snk_quiet = 1'b0;
    int unsigned                n_fail    = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_wait(inout bit quiet);
        if ($urandom_range(0, 31) == 0) quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic int unsigned stored_bytes();
        logic [brf_pkg::PTR_W-1:0] diff;
        diff = wr_ptr - rd_ptr;
        return 32'(diff);
    endfunction

    function automatic void expect_status(int unsigned n);
        int unsigned f;
        f = stored_bytes();
        exp_results.push_back({8'h00, 1'b0, 1'b1, brf_pkg::LEN_W'(n), brf_pkg::FILL_W'(f),
                               brf_pkg::FILL_W'(brf_pkg::DEPTH - 1 - f)});
    endfunction

    function automatic void expect_burst(logic [brf_pkg::PTR_W-1:0] from, int unsigned n);
        int unsigned f;
        f = stored_bytes();
        for (int unsigned i = 0; i < n; i++) begin
            exp_results.push_back({shadow_mem[brf_pkg::PTR_W'(from + i)], 1'b1, (i + 1 == n),
                                   brf_pkg::LEN_W'(n), brf_pkg::FILL_W'(f),
                                   brf_pkg::FILL_W'(brf_pkg::DEPTH - 1 - f)});
        end
    endfunction

    function automatic void model_fifo_cmd(t_fifo_cmd c);
        int unsigned               held;
        int unsigned               want_n;
        int unsigned               n;
        logic [brf_pkg::PTR_W-1:0] base;
        held   = stored_bytes();
        want_n = (32'(c.length) > brf_pkg::MAX_BURST) ? brf_pkg::MAX_BURST : 32'(c.length);
        n      = 0;
        base   = rd_ptr;
        unique case (c.op)
            brf_pkg::OP_WRITE: begin
                if (held < brf_pkg::DEPTH - 1) begin
                    shadow_mem[wr_ptr] = c.write_byte;
                    wr_ptr = wr_ptr + brf_pkg::PTR_W'(1);
                    n = 1;
                end
                expect_status(n);
            end
            brf_pkg::OP_READ, brf_pkg::OP_DISCARD: begin
                n = (want_n < held) ? want_n : held;
                rd_ptr = rd_ptr + brf_pkg::PTR_W'(n);
                if (c.op == brf_pkg::OP_READ && n > 0) expect_burst(base, n);
                else expect_status(n);
            end
            brf_pkg::OP_PEEK: begin
                if (want_n > 0 && 32'(c.peek_offset) + want_n <= held) begin
                    expect_burst(brf_pkg::PTR_W'(base + c.peek_offset), want_n);
                end else begin
                    expect_status(0);
                end
            end
            brf_pkg::OP_CLEAR: begin
                rd_ptr = '0;
                wr_ptr = '0;
                expect_status(0);
            end
            default: expect_status(0);
        endcase
    endfunction

    task automatic push_cmd(input logic [brf_pkg::OP_W-1:0] op, input int unsigned wbyte,
                            input int unsigned len, input int unsigned off);
        t_fifo_cmd c;
        c.op          = op;
        c.write_byte  = brf_pkg::BYTE_W'(wbyte);
        c.length      = brf_pkg::LEN_W'(len);
        c.peek_offset = brf_pkg::OFF_W'(off);
        cmd_queue.push_back(c);
    endtask

    // Driver: presents queued transactions with a random gap after each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                model_fifo_cmd(cur_cmd);
                src_gap = draw_wait(src_quiet);
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    cur_cmd = cmd_queue.pop_front();
                    i_valid       <= 1'b1;
                    i_op          <= cur_cmd.op;
                    i_write_byte  <= cur_cmd.write_byte;
                    i_length      <= cur_cmd.length;
                    i_peek_offset <= cur_cmd.peek_offset;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and stalls for a random time after it.
    always @(posedge i_clk) begin
        t_fifo_result got;
        t_fifo_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_out_byte, o_byte_valid, o_last, o_count, o_fill_level, o_free_space};
                if (exp_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("ERROR: result with nothing pending: byte=%h bv=%b last=%b %s",
                                 got.out_byte, got.byte_valid, got.last,
                                 $sformatf("count=%0d fill=%0d free=%0d", got.count,
                                           got.fill_level, got.free_space));
                    end
                end else begin
                    want = exp_results.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("ERROR: expected byte=%h bv=%b last=%b %s",
                                     want.out_byte, want.byte_valid, want.last,
                                     $sformatf("count=%0d fill=%0d free=%0d", want.count,
                                               want.fill_level, want.free_space));
                            $display("       actual   byte=%h bv=%b last=%b %s",
                                     got.out_byte, got.byte_valid, got.last,
                                     $sformatf("count=%0d fill=%0d free=%0d", got.count,
                                               got.fill_level, got.free_space));
                        end
                    end
                end
                snk_wait = draw_wait(snk_quiet);
            end
            if (snk_wait > 0) begin
                snk_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck = 0;
            else stuck++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned               mode;
        int unsigned               wr_pct;
        int unsigned               r;
        int unsigned               len;
        int unsigned               off;
        logic [brf_pkg::OP_W-1:0]  op;

        // Empty buffer, unused codes and zero lengths, then short writes, reads, peeks, discards and a clear.
        push_cmd(brf_pkg::OP_READ, 8'h00, 4, 0);
        push_cmd(brf_pkg::OP_DISCARD, 8'h00, 3, 0);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 1, 0);
        push_cmd(OP_SPARE_LO, 8'hFF, 127, 1023);
        push_cmd(OP_SPARE_MID, 8'h55, 42, 682);
        push_cmd(OP_SPARE_HI, 8'hAA, 85, 341);
        push_cmd(brf_pkg::OP_WRITE, 8'h00, 0, 0);
        push_cmd(brf_pkg::OP_WRITE, 8'hFF, 127, 1023);
        push_cmd(brf_pkg::OP_WRITE, 8'hA5, 0, 0);
        push_cmd(brf_pkg::OP_WRITE, 8'h5A, 0, 0);
        push_cmd(brf_pkg::OP_WRITE, 8'h3C, 0, 0);
        push_cmd(brf_pkg::OP_WRITE, 8'hC3, 0, 0);
        push_cmd(brf_pkg::OP_READ, 8'h00, 0, 0);
        push_cmd(brf_pkg::OP_DISCARD, 8'h00, 0, 0);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 0, 0);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 4, 2);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 4, 3);
        push_cmd(brf_pkg::OP_READ, 8'h00, 2, 0);
        push_cmd(brf_pkg::OP_DISCARD, 8'h00, 1, 0);
        push_cmd(brf_pkg::OP_READ, 8'h00, 127, 0);
        push_cmd(brf_pkg::OP_WRITE, 8'h81, 0, 0);
        push_cmd(brf_pkg::OP_WRITE, 8'h7E, 0, 0);
        push_cmd(brf_pkg::OP_DISCARD, 8'h00, 100, 0);
        push_cmd(brf_pkg::OP_WRITE, 8'h11, 0, 0);
        push_cmd(brf_pkg::OP_CLEAR, 8'h00, 0, 0);
        push_cmd(brf_pkg::OP_READ, 8'h00, 1, 0);

        // Preload a long run of bytes, then exercise long bursts at the edge of the fill level.
        push_cmd(brf_pkg::OP_CLEAR, 8'h00, 0, 0);
        for (int i = 0; i < PRELOAD_BYTES; i++) begin
            push_cmd(brf_pkg::OP_WRITE, $urandom_range(0, 255), 0, 0);
        end
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 64, PRELOAD_BYTES - 64);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 64, PRELOAD_BYTES - 63);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 1, PRELOAD_BYTES - 1);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 1, PRELOAD_BYTES);
        push_cmd(brf_pkg::OP_READ, 8'h00, 127, 0);
        push_cmd(brf_pkg::OP_DISCARD, 8'h00, 127, 0);
        push_cmd(brf_pkg::OP_PEEK, 8'h00, 127, 0);
        push_cmd(brf_pkg::OP_READ, 8'h00, 64, 0);

        mode = 0;
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            if (i % 40 == 0) mode = $urandom_range(0, 2);
            wr_pct = (mode == 0) ? 80 : ((mode == 1) ? 25 : 50);
            r = $urandom_range(0, 99);
            if (r < wr_pct) begin
                op = brf_pkg::OP_WRITE;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) op = brf_pkg::OP_READ;
                else if (r < 56) op = brf_pkg::OP_DISCARD;
                else if (r < 94) op = brf_pkg::OP_PEEK;
                else if (r < 97) op = brf_pkg::OP_CLEAR;
                else op = OP_SPARE_LO + brf_pkg::OP_W'($urandom_range(0, 2));
            end
            r = $urandom_range(0, 99);
            if (r < 85) len = $urandom_range(1, 6);
            else if (r < 95) len = $urandom_range(0, 127);
            else len = 0;
            off = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(0, 1023);
            push_cmd(op, $urandom_range(0, 255), len, off);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (cmd_queue.size() != 0 || i_valid || exp_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0 && exp_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/brf_pkg.sv
src/byte_ring_fifo_with_peek.sv
tb/sv/tb_byte_ring_fifo_with_peek.sv
